>>> hdl/quaternion_to_euler_angles_assert.svh
// Assertion macros used by the checker of the quaternion to Euler block.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// cond must hold at every clock edge outside reset
`define Q2E_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/q2e_pkg.sv
// Types, widths and constants of the quaternion to Euler angle block.
package q2e_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;

  localparam int QW       = 16;  // quaternion part
  localparam int PW       = 32;  // 16x16 product
  localparam int OW       = 34;  // atan2 operands
  localparam int AW       = 28;  // magnitude of the pitch sine term
  localparam int RW       = 58;  // square root working words
  localparam int SQ_STEPS = 29;  // result bits of the square root
  localparam int CW       = 37;  // CORDIC x and y
  localparam int ZW       = 32;  // CORDIC angle, 2^-22 degree
  localparam int FW       = 16;  // rounded angle

  localparam logic signed [ZW-1:0] DEG90  = 32'sd377487360;
  localparam logic signed [ZW-1:0] DEG180 = 32'sd754974720;

  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  typedef logic signed [QW-1:0] quat_t;
  typedef logic signed [14:0]   roll_t;
  typedef logic signed [13:0]   pitch_t;
  typedef logic        [14:0]   yaw_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

>>> hdl/q2e_if.sv
// Valid/ready channels: quaternion in, Euler angles out.
interface q2e_quat_if;
  import q2e_pkg::*;
  logic  valid;
  logic  ready;
  quat_t quat_w;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  import q2e_pkg::*;
  logic   valid;
  logic   ready;
  roll_t  roll_angle;
  pitch_t pitch_angle;
  yaw_t   yaw_angle;
  logic   pitch_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

>>> hdl/quaternion_to_euler_angles.sv
// Quaternion to roll, pitch and compass yaw: a fully pipelined CORDIC datapath.
//
// quat_i takes one Q1.14 quaternion (w, x, y, z) per valid/ready handshake;
// euler_o gives roll and pitch in signed degrees and yaw in [0, 360), all with
// 64 steps per degree, plus a flag when the pitch sine term reached one.
// Its stages are products, sums, squaring of the pitch term, 29 square root
// stages (one result bit each), one quadrant stage, one stage per CORDIC
// iteration and an output register.
// Throughput is one item per cycle while the output is not stalled; the three
// atan2 run in parallel lanes. Each stage's valid bit travels with its data.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and quat_i.ready drops; bubbles ahead of the output do not stall input
// once the output register is free.
// Reset clears all valid bits; no item is in flight afterwards.
module quaternion_to_euler_angles (
  input  logic        clk_i,
  input  logic        rst_ni,
  q2e_quat_if.sink    quat_i,
  q2e_euler_if.source euler_o
);
  import q2e_pkg::*;

  localparam int NSTG = 3 + SQ_STEPS + 1 + CORDIC_STEPS + 1;
  localparam logic signed [OW-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic [RW-1:0] SQ_TOP = RW'(1) << 56;
  localparam logic signed [FW-1:0] ANG_MAX = 16'sd11520;
  localparam logic signed [FW-1:0] PITCH_MAX = 16'sd5760;
  localparam logic signed [FW-1:0] FULL_TURN = 16'sd23040;

  typedef struct packed {
    logic signed [OW-1:0] sr;
    logic signed [OW-1:0] cr;
    logic signed [OW-1:0] sp;
    logic signed [OW-1:0] fx;
    logic signed [OW-1:0] fy;
    logic                 clamp;
  } ops_t;

  typedef struct packed {
    ops_t          ops;
    logic [RW-1:0] v;
    logic [RW-1:0] res;
  } sq_t;

  typedef struct packed {
    cordic_t roll;
    cordic_t pitch;
    cordic_t yaw;
    logic    clamp;
    logic    pneg;
  } cs_t;

  function automatic cordic_t prerot(input logic signed [CW-1:0] y,
                                     input logic signed [CW-1:0] x);
    cordic_t c;
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = DEG90;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -DEG90;
      end
    end
    return c;
  endfunction

  function automatic cordic_t rotate(input cordic_t c, input int sh,
                                     input logic signed [ZW-1:0] ang);
    cordic_t n;
    n = c;
    if (c.y > 0) begin
      n.x = c.x + (c.y >>> sh);
      n.y = c.y - (c.x >>> sh);
      n.z = c.z + ang;
    end else if (c.y < 0) begin
      n.x = c.x - (c.y >>> sh);
      n.y = c.y + (c.x >>> sh);
      n.z = c.z - ang;
    end
    return n;
  endfunction

  // clamp to half a turn, round half up to 2^-6 degree
  function automatic logic signed [FW-1:0] finish(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] zc;
    logic signed [ZW-1:0] zr;
    logic signed [FW-1:0] r;
    zc = z;
    if (zc > DEG180) zc = DEG180;
    if (zc < -DEG180) zc = -DEG180;
    zr = (zc + 32'sd32768) >>> 16;
    r = zr[FW-1:0];
    if (r > ANG_MAX) r = ANG_MAX;
    if (r < -ANG_MAX) r = -ANG_MAX;
    return r;
  endfunction

  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en           = ~vld_q[NSTG-1] | euler_o.ready;
  assign quat_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], quat_i.valid};
    end
  end

  // products
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, xy_q, wz_q, zz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= PW'(quat_i.quat_w) * PW'(quat_i.quat_x);
      yz_q <= PW'(quat_i.quat_y) * PW'(quat_i.quat_z);
      xx_q <= PW'(quat_i.quat_x) * PW'(quat_i.quat_x);
      yy_q <= PW'(quat_i.quat_y) * PW'(quat_i.quat_y);
      wy_q <= PW'(quat_i.quat_w) * PW'(quat_i.quat_y);
      zx_q <= PW'(quat_i.quat_z) * PW'(quat_i.quat_x);
      xy_q <= PW'(quat_i.quat_x) * PW'(quat_i.quat_y);
      wz_q <= PW'(quat_i.quat_w) * PW'(quat_i.quat_z);
      zz_q <= PW'(quat_i.quat_z) * PW'(quat_i.quat_z);
    end
  end

  // operand sums and squaring of the pitch term
  ops_t          ops_d, ops_q, ops3_q;
  logic [AW-1:0] mag_d, mag_q;
  logic [2*AW-1:0] asq_q;

  always_comb begin
    ops_d.sr    = (OW'(wx_q) + OW'(yz_q)) <<< 1;
    ops_d.cr    = ONE_Q28 - ((OW'(xx_q) + OW'(yy_q)) <<< 1);
    ops_d.sp    = (OW'(wy_q) - OW'(zx_q)) <<< 1;
    ops_d.fx    = (OW'(xy_q) - OW'(wz_q)) <<< 1;
    ops_d.fy    = ONE_Q28 - ((OW'(xx_q) + OW'(zz_q)) <<< 1);
    ops_d.clamp = (ops_d.sp >= ONE_Q28) || (ops_d.sp <= -ONE_Q28);
    mag_d       = ops_d.sp[OW-1] ? AW'(-ops_d.sp) : AW'(ops_d.sp);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ops_q  <= ops_d;
      mag_q  <= mag_d;
      ops3_q <= ops_q;
      asq_q  <= mag_q * mag_q;
    end
  end

  // square root of 1 - s^2, one result bit per stage
  sq_t sq_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    sq_t           sq_in;
    sq_t           sq_d;
    logic [RW-1:0] bit_k;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      always_comb begin
        sq_in.ops = ops3_q;
        sq_in.v   = SQ_TOP - RW'(asq_q);
        sq_in.res = '0;
      end
    end else begin : g_next
      assign sq_in = sq_q[k-1];
    end

    assign bit_k = RW'(1) << (56 - 2 * k);
    assign trial = sq_in.res + bit_k;

    always_comb begin
      sq_d = sq_in;
      if (sq_in.v >= trial) begin
        sq_d.v   = sq_in.v - trial;
        sq_d.res = (sq_in.res >> 1) + bit_k;
      end else begin
        sq_d.res = sq_in.res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) sq_q[k] <= sq_d;
    end
  end

  // quadrant fold, then CORDIC iterations in three lanes
  cs_t cs_q [CORDIC_STEPS+1];
  cs_t pre_d;
  sq_t sq_last;

  assign sq_last = sq_q[SQ_STEPS-1];

  always_comb begin
    pre_d.roll  = prerot(CW'(sq_last.ops.sr), CW'(sq_last.ops.cr));
    pre_d.pitch = prerot(CW'(sq_last.ops.sp),
                         CW'($signed({1'b0, sq_last.res[SQ_STEPS-1:0]})));
    pre_d.yaw   = prerot(CW'(sq_last.ops.fx), CW'(sq_last.ops.fy));
    pre_d.clamp = sq_last.ops.clamp;
    pre_d.pneg  = sq_last.ops.sp[OW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) cs_q[0] <= pre_d;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cs_t cs_d;
    always_comb begin
      cs_d       = cs_q[i];
      cs_d.roll  = rotate(cs_q[i].roll, i, ATAN_TAB[i]);
      cs_d.pitch = rotate(cs_q[i].pitch, i, ATAN_TAB[i]);
      cs_d.yaw   = rotate(cs_q[i].yaw, i, ATAN_TAB[i]);
    end
    always_ff @(posedge clk_i) begin
      if (en) cs_q[i+1] <= cs_d;
    end
  end

  // round, clamp and wrap
  cs_t                  cs_last;
  logic signed [FW-1:0] roll_d, pitch_d, yaw_d;
  roll_t                roll_q;
  pitch_t               pitch_q;
  yaw_t                 yaw_q;
  logic                 clamp_q;

  assign cs_last = cs_q[CORDIC_STEPS];

  always_comb begin
    roll_d  = finish(cs_last.roll.z);
    pitch_d = finish(cs_last.pitch.z);
    yaw_d   = finish(cs_last.yaw.z);
    if (pitch_d > PITCH_MAX) pitch_d = PITCH_MAX;
    if (pitch_d < -PITCH_MAX) pitch_d = -PITCH_MAX;
    if (cs_last.clamp) pitch_d = cs_last.pneg ? -PITCH_MAX : PITCH_MAX;
    if (yaw_d < 0) yaw_d = yaw_d + FULL_TURN;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_d[14:0];
      pitch_q <= pitch_d[13:0];
      yaw_q   <= yaw_d[14:0];
      clamp_q <= cs_last.clamp;
    end
  end

  assign euler_o.valid         = vld_q[NSTG-1];
  assign euler_o.roll_angle    = roll_q;
  assign euler_o.pitch_angle   = pitch_q;
  assign euler_o.yaw_angle     = yaw_q;
  assign euler_o.pitch_clamped = clamp_q;

endmodule

>>> hdl/q2e_checker.sv
// Port-level checks of the quaternion to Euler block, bound to its top level.
`include "quaternion_to_euler_angles_assert.svh"

module q2e_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input q2e_pkg::roll_t  roll_i,
  input q2e_pkg::pitch_t pitch_i,
  input q2e_pkg::yaw_t   yaw_i,
  input logic            clamped_i
);
  import q2e_pkg::*;

  `Q2E_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result item dropped while stalled")
  `Q2E_ASSERT_ALWAYS(a_clamp_pitch, clk_i, rst_ni, !(out_valid_i && clamped_i) || pitch_i == 14'sd5760 || pitch_i == -14'sd5760, "clamped pitch not at 90 degrees")
  `Q2E_ASSERT_ALWAYS(a_yaw_range, clk_i, rst_ni, !out_valid_i || yaw_i < 15'd23040, "yaw reached 360 degrees")
  `Q2E_ASSERT_ALWAYS(a_roll_range, clk_i, rst_ni, !out_valid_i || (roll_i <= 15'sd11520 && roll_i >= -15'sd11520), "roll beyond 180 degrees")

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (euler_o.valid),
  .out_ready_i (euler_o.ready),
  .roll_i      (euler_o.roll_angle),
  .pitch_i     (euler_o.pitch_angle),
  .yaw_i       (euler_o.yaw_angle),
  .clamped_i   (euler_o.pitch_clamped)
);

>>> tb/q2e_tb_if.sv
// Testbench constants: pipeline latency of the block under test.
package q2e_tb_pkg;
  localparam int LATENCY = 50;
endpackage

>>> tb/tb.sv
// Testbench of quaternion_to_euler_angles: random and corner quaternions, CORDIC predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import q2e_pkg::*;

  typedef struct {
    quat_t w, x, y, z;
  } quat_item_t;

  typedef struct {
    roll_t  roll;
    pitch_t pitch;
    yaw_t   yaw;
    logic   clamped;
  } euler_t;

  localparam longint ONE_Q28  = 64'sd1 << 28;
  localparam longint ANG180   = 64'sd180 << 22;
  localparam longint ANG90    = 64'sd90 << 22;
  localparam int     LIMIT    = 400000;

  logic clk_i = 0;
  logic rst_ni = 0;
  q2e_quat_if  quat_ch();
  q2e_euler_if euler_ch();

  quaternion_to_euler_angles dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .quat_i(quat_ch.sink), .euler_o(euler_ch.source)
  );

  quat_item_t pending_q[$];
  euler_t     angles_due[$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 47;
  bit in_taken = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sqrt_u64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint atan2_deg(longint yv, longint xv);
    longint ang, t, xs, ys;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; ang = ANG90;
      end else begin
        t = xv; xv = -yv; yv = t; ang = -ANG90;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      xs = shr_floor(xv, i);
      ys = shr_floor(yv, i);
      if (yv > 0) begin
        xv = xv + ys; yv = yv - xs; ang += longint'(ATAN_TAB[i]);
      end else if (yv < 0) begin
        xv = xv - ys; yv = yv + xs; ang -= longint'(ATAN_TAB[i]);
      end
    end
    if (ang > ANG180) ang = ANG180;
    if (ang < -ANG180) ang = -ANG180;
    ang = shr_floor(ang + (64'sd1 << 15), 16);
    if (ang > 11520) ang = 11520;
    if (ang < -11520) ang = -11520;
    return ang;
  endfunction

  function automatic euler_t euler_of(quat_item_t q);
    longint w, x, y, z, sr, cr, sp, fx, fy, r, p, yw;
    longint unsigned a;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    sr = 2 * (w * x + y * z);
    cr = ONE_Q28 - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    fx = 2 * (x * y - w * z);
    fy = ONE_Q28 - 2 * (x * x + z * z);
    r = atan2_deg(sr, cr);
    e.clamped = 0;
    if (sp >= ONE_Q28) begin
      p = 5760; e.clamped = 1;
    end else if (sp <= -ONE_Q28) begin
      p = -5760; e.clamped = 1;
    end else begin
      a = (sp < 0) ? -sp : sp;
      p = atan2_deg(sp, sqrt_u64((64'd1 << 56) - a * a));
      if (p > 5760) p = 5760;
      if (p < -5760) p = -5760;
    end
    yw = atan2_deg(fx, fy);
    if (yw < 0) yw += 23040;
    e.roll = roll_t'(r);
    e.pitch = pitch_t'(p);
    e.yaw = yaw_t'(yw);
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic push_quat(int w, int x, int y, int z);
    quat_item_t q;
    q.w = quat_t'(w); q.x = quat_t'(x); q.y = quat_t'(y); q.z = quat_t'(z);
    pending_q.push_back(q);
  endtask

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // driver: present items at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      quat_ch.valid <= 0;
    end else if (!quat_ch.valid || in_taken) begin
      // advance once the item on the bus was taken at the last rising edge
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        quat_item_t q;
        q = pending_q.pop_front();
        quat_ch.valid <= 1;
        quat_ch.quat_w <= q.w; quat_ch.quat_x <= q.x;
        quat_ch.quat_y <= q.y; quat_ch.quat_z <= q.z;
      end else begin
        quat_ch.valid <= 0;
      end
    end
    euler_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk_i) begin
    in_taken = quat_ch.valid && quat_ch.ready && rst_ni;
    if (rst_ni) begin
      cycle_cnt++;
      if (quat_ch.valid && quat_ch.ready) begin
        quat_item_t q;
        q.w = quat_ch.quat_w; q.x = quat_ch.quat_x;
        q.y = quat_ch.quat_y; q.z = quat_ch.quat_z;
        angles_due.push_back(euler_of(q));
      end
      if (euler_ch.valid && euler_ch.ready) begin
        if (angles_due.size() == 0) begin
          report_mismatch("unexpected result, queue depth", 0, 1);
        end else begin
          euler_t e;
          e = angles_due.pop_front();
          if (euler_ch.roll_angle !== e.roll)
            report_mismatch("roll_angle", euler_ch.roll_angle, e.roll);
          if (euler_ch.pitch_angle !== e.pitch)
            report_mismatch("pitch_angle", euler_ch.pitch_angle, e.pitch);
          if (euler_ch.yaw_angle !== e.yaw)
            report_mismatch("yaw_angle", euler_ch.yaw_angle, e.yaw);
          if (euler_ch.pitch_clamped !== e.clamped)
            report_mismatch("pitch_clamped", euler_ch.pitch_clamped, e.clamped);
        end
      end
      if (cycle_cnt > LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int mag, ang;
    quat_ch.valid = 0;
    quat_ch.quat_w = 0; quat_ch.quat_x = 0; quat_ch.quat_y = 0; quat_ch.quat_z = 0;
    euler_ch.ready = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // corners: identity, zeros, extremes, gimbal lock both signs, +180 cases
    push_quat(16384, 0, 0, 0);
    push_quat(0, 0, 0, 0);
    push_quat(32767, 32767, 32767, 32767);
    push_quat(-32768, -32768, -32768, -32768);
    push_quat(-32768, 32767, -32768, 32767);
    push_quat(11585, 0, 11585, 0);
    push_quat(11585, 0, -11585, 0);
    push_quat(11585, 11585, 11585, 11585);
    push_quat(0, 16384, 0, 0);
    push_quat(0, 0, 0, 16384);
    push_quat(0, 0, 16384, 0);
    push_quat(16384, 0, 0, 1);
    push_quat(16384, 0, 0, -1);
    push_quat(8192, 8192, 8192, -8192);
    push_quat(-16384, 0, 0, 0);
    push_quat(0, 11585, 0, 11585);
    push_quat(32767, 0, 0, 0);
    push_quat(0, -32768, 0, 0);
    push_quat(1, -1, 1, -1);
    push_quat(-1, 1, -1, 1);

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 500; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          push_quat(rnd16(), rnd16(), rnd16(), rnd16());
        end else begin
          // near-unit quaternion: mostly well formed inputs
          int w, x, y, z;
          real s;
          w = $urandom_range(0, 32767) - 16384; x = $urandom_range(0, 32767) - 16384;
          y = $urandom_range(0, 32767) - 16384; z = $urandom_range(0, 32767) - 16384;
          s = $sqrt(real'(w * w + x * x + y * y + z * z) + 1.0);
          mag = 16384 + $urandom_range(0, 40) - 20;
          ang = mag;
          push_quat($rtoi(w * ang / s), $rtoi(x * ang / s),
                    $rtoi(y * ang / s), $rtoi(z * ang / s));
        end
      end
      wait (pending_q.size() == 0);
      if (ph == 0) begin
        send_idle_pct = 47; recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
    end
    wait (pending_q.size() == 0 && !quat_ch.valid && angles_due.size() == 0);
    repeat (q2e_tb_pkg::LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/q2e_pkg.sv
hdl/q2e_if.sv
hdl/quaternion_to_euler_angles.sv
hdl/q2e_checker.sv
tb/q2e_tb_if.sv
tb/tb.sv
